[rtl/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants of the smoothing / difference filter
// Field widths, register indexes, tap weight codes and control bundles.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int VALUE_W      = 32;
  localparam int KIND_W       = 1;
  localparam int ORDER_W      = 2;
  localparam int SPAN_W       = 4;
  localparam int GAIN_W       = 21;
  localparam int RECIP_W      = 16;
  localparam int COEF_W       = 22;
  localparam int SEEN_W       = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 21;
  localparam int DEF_MAX_SPAN = 15;

  localparam logic [SEEN_W-1:0] SEEN_MAX = 5'd31;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_KIND      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIVATIVE_ORDER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_SPAN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SPAN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_RECIP    = 3'd5;

  // register reset values
  localparam logic [KIND_W-1:0]         RST_FILTER_KIND      = 1'b1;
  localparam logic [ORDER_W-1:0]        RST_DERIVATIVE_ORDER = 2'd0;
  localparam logic [SPAN_W-1:0]         RST_LEFT_SPAN        = 4'd7;
  localparam logic [SPAN_W-1:0]         RST_RIGHT_SPAN       = 4'd7;
  localparam logic signed [GAIN_W-1:0]  RST_DERIV_GAIN       = 21'sd4096;
  localparam logic [RECIP_W-1:0]        RST_AVERAGE_RECIP    = 16'd4369;

  // filter kinds and derivative orders
  localparam logic [KIND_W-1:0]  KIND_NONE   = 1'b0;
  localparam logic [KIND_W-1:0]  KIND_AVG    = 1'b1;
  localparam logic [ORDER_W-1:0] ORD_VALUE   = 2'd0;
  localparam logic [ORDER_W-1:0] ORD_FIRST   = 2'd1;
  localparam logic [ORDER_W-1:0] ORD_SECOND  = 2'd2;
  localparam logic [ORDER_W-1:0] ORD_THIRD   = 2'd3;

  // unity gain in Q10.12, used for the plain pass-through
  localparam logic signed [COEF_W-1:0] UNITY_Q12 = 22'sd4096;

  // tap weight codes
  typedef logic [1:0] weight_t;
  localparam weight_t W_ZERO = 2'd0;
  localparam weight_t W_POS  = 2'd1;
  localparam weight_t W_NEG  = 2'd2;
  localparam weight_t W_NEG2 = 2'd3;

  typedef struct packed {
    logic    acc_en;
    logic    first;
    weight_t weight;
    logic    mul_en;
    logic    rnd_en;
    logic    shift16;
  } mac_ctrl_t;

  typedef struct packed {
    logic push;
    logic zero;
    logic clear;
  } win_ctrl_t;

endpackage

[rtl/wsd_in_if.sv]
// ----------------------------------------------------------------------------
// wsd_in_if: input sample channel
// Valid/ready channel carrying one sample and its record end mark.
// ----------------------------------------------------------------------------
interface wsd_in_if;
  import wsd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       record_end;

  modport source (output valid, output sample, output record_end, input ready);
  modport sink   (input valid, input sample, input record_end, output ready);
endinterface

[rtl/wsd_out_if.sv]
// ----------------------------------------------------------------------------
// wsd_out_if: filtered result channel
// Valid/ready channel carrying one filtered value and its last mark.
// ----------------------------------------------------------------------------
interface wsd_out_if;
  import wsd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

[rtl/wsd_cfg_if.sv]
// ----------------------------------------------------------------------------
// wsd_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface wsd_cfg_if;
  import wsd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/windowed_smoothing_derivative_fir_top.sv]
// ----------------------------------------------------------------------------
// windowed_smoothing_derivative_fir_top: smoothing / difference FIR filter
// Moving average, first and second difference over a zero-padded window.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                         | handshake
//  ---------+-----+---------------------------------+-------------------------
//  in_ch    | in  | sample[15:0] s, record_end      | valid/ready, request
//  out_ch   | out | value[31:0] s, last             | valid/ready, registered
//  cfg_ch   | in  | index[2:0], data[20:0]          | valid/ready, always ready
//
//  A request that yields a result passes accept, check, n+1 taps through
//  the single MAC, then multiply, round, load; one that yields none goes
//  back to idle after the check. A request with record_end pads zeros up
//  to the lookahead, then flushes its results; n = left_span+right_span
//  for the moving average, 2 for plain differences, 0 for pass-through.
//  Reset is synchronous; the window clears at once, no clearing pass.
//  in_ch.ready is low while a request is in work; a full output register
//  that is not taken holds the sequencer in its load step.
//
module windowed_smoothing_derivative_fir_top #(
  parameter int MAX_SPAN = wsd_pkg::DEF_MAX_SPAN
) (
  input logic      clk,
  input logic      rst_n,
  wsd_in_if.sink   in_ch,
  wsd_out_if.source out_ch,
  wsd_cfg_if.sink  cfg_ch
);
  import wsd_pkg::*;

  localparam int WIN_DEPTH = 2 * MAX_SPAN + 1;
  localparam int IDX_W     = $clog2(WIN_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_PAD   = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_RND   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  // configuration registers
  logic [KIND_W-1:0]        filter_kind_r;
  logic [ORDER_W-1:0]       derivative_order_r;
  logic [SPAN_W-1:0]        left_span_r;
  logic [SPAN_W-1:0]        right_span_r;
  logic signed [GAIN_W-1:0] deriv_gain_r;
  logic [RECIP_W-1:0]       average_recip_r;

  // sequencer state
  logic [2:0]        state_r, state_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic              end_r, end_nxt;
  logic [SEEN_W-1:0] pad_r, pad_nxt;
  logic [SEEN_W-1:0] out_left_r, out_left_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_value_r;
  logic                      out_last_r;
  logic                      out_load;

  // derived tap layout
  logic [ORDER_W-1:0]       eff_ord;
  logic [IDX_W-1:0]         nl, nr, n_taps;
  logic [SEEN_W-1:0]        look, look_p1, e_cnt;
  weight_t                  weight;
  logic signed [COEF_W-1:0] coef;
  logic                     shift16;

  win_ctrl_t                  win_ctrl;
  mac_ctrl_t                  mac_ctrl;
  logic signed [SAMPLE_W-1:0] tap_data;
  logic signed [VALUE_W-1:0]  mac_result;
  logic                       in_acc;

  assign in_acc = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------- config
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_kind_r      <= RST_FILTER_KIND;
      derivative_order_r <= RST_DERIVATIVE_ORDER;
      left_span_r        <= RST_LEFT_SPAN;
      right_span_r       <= RST_RIGHT_SPAN;
      deriv_gain_r       <= RST_DERIV_GAIN;
      average_recip_r    <= RST_AVERAGE_RECIP;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FILTER_KIND:      filter_kind_r      <= cfg_ch.data[KIND_W-1:0];
        REG_DERIVATIVE_ORDER: derivative_order_r <= cfg_ch.data[ORDER_W-1:0];
        REG_LEFT_SPAN:        left_span_r        <= cfg_ch.data[SPAN_W-1:0];
        REG_RIGHT_SPAN:       right_span_r       <= cfg_ch.data[SPAN_W-1:0];
        REG_DERIV_GAIN:       deriv_gain_r       <= cfg_ch.data[GAIN_W-1:0];
        REG_AVERAGE_RECIP:    average_recip_r    <= cfg_ch.data[RECIP_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ------------------------------------------------------------ tap layout
  always_comb begin
    // treat order three as the smoothed value
    eff_ord = (derivative_order_r == ORD_THIRD) ? ORD_VALUE : derivative_order_r;

    // clamp both spans to the window capacity
    nl = (32'(left_span_r) > MAX_SPAN) ? IDX_W'(MAX_SPAN) : IDX_W'(left_span_r);
    nr = (32'(right_span_r) > MAX_SPAN) ? IDX_W'(MAX_SPAN) : IDX_W'(right_span_r);

    if (filter_kind_r == KIND_AVG) begin
      look   = SEEN_W'(nr);
      n_taps = nl + nr;
    end else begin
      look   = (eff_ord == ORD_VALUE) ? SEEN_W'(0) : SEEN_W'(1);
      n_taps = (eff_ord == ORD_VALUE) ? IDX_W'(0) : IDX_W'(2);
    end
    look_p1 = look + SEEN_W'(1);
    e_cnt   = (seen_r < look_p1) ? seen_r : look_p1;

    // per-tap weight
    weight = W_POS;
    if (filter_kind_r == KIND_AVG) begin
      case (eff_ord)
        ORD_FIRST: begin
          if (j_r < nl) weight = W_POS;
          else if (j_r == nl) weight = W_ZERO;
          else weight = W_NEG;
        end
        ORD_SECOND: weight = (j_r == nl) ? W_NEG2 : W_POS;
        default:    weight = W_POS;
      endcase
    end else begin
      case (eff_ord)
        ORD_FIRST: begin
          if (j_r == IDX_W'(0)) weight = W_POS;
          else if (j_r == IDX_W'(1)) weight = W_ZERO;
          else weight = W_NEG;
        end
        ORD_SECOND: weight = (j_r == IDX_W'(1)) ? W_NEG2 : W_POS;
        default:    weight = W_POS;
      endcase
    end

    // scale: unity for pass-through, reciprocal for the average, else gain
    if (eff_ord != ORD_VALUE) begin
      coef    = COEF_W'(deriv_gain_r);
      shift16 = 1'b0;
    end else if (filter_kind_r == KIND_AVG) begin
      coef    = $signed({{(COEF_W-RECIP_W){1'b0}}, average_recip_r});
      shift16 = 1'b1;
    end else begin
      coef    = UNITY_Q12;
      shift16 = 1'b0;
    end
  end

  // ------------------------------------------------------------- sequencer
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_load    = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    seen_nxt      = seen_r;
    end_nxt       = end_r;
    pad_nxt       = pad_r;
    out_left_nxt  = out_left_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    win_ctrl      = '0;
    mac_ctrl      = '0;
    mac_ctrl.weight  = weight;
    mac_ctrl.first   = (j_r == '0);
    mac_ctrl.shift16 = shift16;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // push the new sample and count it
          win_ctrl.push = 1'b1;
          end_nxt       = in_ch.record_end;
          if (seen_r < SEEN_MAX) seen_nxt = seen_r + SEEN_W'(1);
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        j_nxt = '0;
        if (!end_r) begin
          out_left_nxt = SEEN_W'(1);
          state_nxt    = (seen_r > look) ? S_ACC : S_IDLE;
        end else begin
          // pad up to the lookahead, then flush e results
          pad_nxt      = look_p1 - e_cnt;
          out_left_nxt = e_cnt;
          state_nxt    = S_PAD;
        end
      end
      S_PAD: begin
        if (pad_r != '0) begin
          win_ctrl.push = 1'b1;
          win_ctrl.zero = 1'b1;
          pad_nxt       = pad_r - SEEN_W'(1);
        end else begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        if (j_r == n_taps) begin
          state_nxt = S_MUL;
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_nxt       = S_RND;
      end
      S_RND: begin
        mac_ctrl.rnd_en = 1'b1;
        state_nxt       = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          j_nxt         = '0;
          if (end_r && out_left_r > SEEN_W'(1)) begin
            // advance the flush by one zero sample
            win_ctrl.push = 1'b1;
            win_ctrl.zero = 1'b1;
            out_left_nxt  = out_left_r - SEEN_W'(1);
            state_nxt     = S_ACC;
          end else begin
            if (end_r) begin
              win_ctrl.clear = 1'b1;
              seen_nxt       = '0;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seen_r      <= '0;
      end_r       <= 1'b0;
      pad_r       <= '0;
      out_left_r  <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      end_r       <= end_nxt;
      pad_r       <= pad_nxt;
      out_left_r  <= out_left_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= mac_result;
      out_last_r  <= end_r && (out_left_r == SEEN_W'(1));
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.value = out_value_r;
  assign out_ch.last  = out_last_r;

  // ---------------------------------------------------------- datapath
  wsd_window #(
    .MAX_SPAN (MAX_SPAN)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (win_ctrl),
    .push_data (in_ch.sample),
    .tap_idx   (j_r),
    .tap_data  (tap_data)
  );

  wsd_mac #(
    .MAX_SPAN (MAX_SPAN)
  ) u_mac (
    .clk      (clk),
    .ctrl     (mac_ctrl),
    .tap_data (tap_data),
    .coef     (coef),
    .result   (mac_result)
  );

  // --------------------------------------------------------- assertions
  a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> (j_r <= n_taps))
    else $error("tap counter ran past the last tap");

  a_pad_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAD) |-> (out_left_r != '0))
    else $error("flush started with no result to give");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && end_r && out_left_r == SEEN_W'(1)) |=> (seen_r == '0))
    else $error("record end did not clear the sample count");

  a_last_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !end_r) |=> !out_ch.last)
    else $error("last mark on a result outside a record flush");

endmodule

[rtl/wsd_window.sv]
// ----------------------------------------------------------------------------
// wsd_window: sample window shift line
// Newest sample at tap 0; one tap is selected for the shared MAC.
// ----------------------------------------------------------------------------
module wsd_window #(
  parameter int MAX_SPAN = wsd_pkg::DEF_MAX_SPAN,
  localparam int WIN_DEPTH = 2 * MAX_SPAN + 1,
  localparam int IDX_W = $clog2(WIN_DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wsd_pkg::win_ctrl_t                  ctrl,
  input  logic signed [wsd_pkg::SAMPLE_W-1:0] push_data,
  input  logic [IDX_W-1:0]                    tap_idx,
  output logic signed [wsd_pkg::SAMPLE_W-1:0] tap_data
);
  import wsd_pkg::*;

  logic signed [SAMPLE_W-1:0] win_r [WIN_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
    end else if (ctrl.push) begin
      win_r[0] <= ctrl.zero ? '0 : push_data;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  assign tap_data = win_r[tap_idx];

endmodule

[rtl/wsd_mac.sv]
// ----------------------------------------------------------------------------
// wsd_mac: shared multiply-accumulate unit
// Accumulates weighted taps, scales by one coefficient, rounds, saturates.
// ----------------------------------------------------------------------------
module wsd_mac #(
  parameter int MAX_SPAN = wsd_pkg::DEF_MAX_SPAN
) (
  input  logic                                clk,
  input  wsd_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [wsd_pkg::SAMPLE_W-1:0] tap_data,
  input  logic signed [wsd_pkg::COEF_W-1:0]   coef,
  output logic signed [wsd_pkg::VALUE_W-1:0]  result
);
  import wsd_pkg::*;

  // worst case magnitude: (2*MAX_SPAN+2) full-scale samples
  localparam int ACC_W = SAMPLE_W + $clog2(2 * MAX_SPAN + 2) + 1;
  localparam int PW    = ACC_W + COEF_W;

  localparam logic signed [PW-1:0] SAT_MAX = {{(PW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [PW-1:0] SAT_MIN = {{(PW-31){1'b1}}, {31{1'b0}}};
  localparam logic signed [PW-1:0] HALF12  = PW'(1) <<< 11;
  localparam logic signed [PW-1:0] HALF16  = PW'(1) <<< 15;

  logic signed [ACC_W-1:0]   acc_r, acc_nxt, term;
  logic signed [PW-1:0]      prod_r, prod_nxt, biased, shifted;
  logic signed [VALUE_W-1:0] result_r, result_nxt;

  always_comb begin
    case (ctrl.weight)
      W_POS:   term = ACC_W'(tap_data);
      W_NEG:   term = -ACC_W'(tap_data);
      W_NEG2:  term = -(ACC_W'(tap_data) <<< 1);
      default: term = '0;
    endcase
    acc_nxt = ctrl.first ? term : acc_r + term;
  end

  assign prod_nxt = acc_r * coef;

  // round half toward plus infinity, then clamp to 32 bits
  always_comb begin
    biased  = prod_r + (ctrl.shift16 ? HALF16 : HALF12);
    shifted = ctrl.shift16 ? (biased >>> 16) : (biased >>> 12);
    if (shifted > SAT_MAX) begin
      result_nxt = VALUE_W'(SAT_MAX);
    end else if (shifted < SAT_MIN) begin
      result_nxt = VALUE_W'(SAT_MIN);
    end else begin
      result_nxt = shifted[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_en) begin
      acc_r <= acc_nxt;
    end
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.rnd_en) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule
